// ===== hw/rtl/vgc_pkg.sv =====
`timescale 1ns / 1ps

package vgc_pkg;

  // Input field widths
  localparam int unsigned POS_W  = 11;
  localparam int unsigned IDX_W  = 10;  // in-range coordinate, non-negative part
  localparam int unsigned TOP_W  = 6;   // reported height width
  localparam int unsigned EXT_W  = 10;  // widest internal height

  // Operation codes
  localparam logic OP_READ  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Classified command between front and back
  typedef struct packed {
    logic               wr;
    logic               in_range;
    logic               tile_nz;
    logic [IDX_W-1:0]   pos_x;
    logic [IDX_W-1:0]   pos_y;
    logic [IDX_W-1:0]   pos_z;
  } vgc_cmd_t;

  // Result item
  typedef struct packed {
    logic               is_solid;
    logic               is_dark;
    logic               write_done;
    logic [TOP_W-1:0]   column_top;
    logic               column_changed;
    logic [TOP_W-1:0]   span_low;
    logic [TOP_W-1:0]   span_high;
  } vgc_res_t;

  // Back-end sequencer
  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_ADDR,
    ST_READ,
    ST_EVAL,
    ST_SCAN,
    ST_WRITE,
    ST_DONE
  } vgc_state_e;

endpackage

// ===== hw/rtl/vgc_fifo.sv =====
`timescale 1ns / 1ps

module vgc_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 2
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [WIDTH-1:0] data_i,
  output logic             full_o,
  input  logic             pop_i,
  output logic [WIDTH-1:0] data_o,
  output logic             empty_o
);

  localparam int unsigned PW = $clog2(DEPTH);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [PW:0]      wr_ptr_q, wr_ptr_d;
  logic [PW:0]      rd_ptr_q, rd_ptr_d;
  logic             do_push, do_pop;

  // Flag full and empty from pointer wrap bits
  assign full_o  = (wr_ptr_q[PW] != rd_ptr_q[PW]) && (wr_ptr_q[PW-1:0] == rd_ptr_q[PW-1:0]);
  assign empty_o = (wr_ptr_q == rd_ptr_q);
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_ptr_q[PW-1:0]];

  // Advance pointers on each transfer
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    if (do_push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
    end
  end

  // Hold entry data
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q[PW-1:0]] <= data_i;
    end
  end

  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (wr_ptr_q - rd_ptr_q) <= (PW+1)'(DEPTH))
    else $error("fifo holds more entries than its depth");

endmodule

// ===== hw/rtl/vgc_front.sv =====
`timescale 1ns / 1ps

module vgc_front
  import vgc_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_LENGTH = 256,
  parameter int unsigned GRID_HEIGHT = 64
) (
  input  logic             push_i,
  output logic             full_o,
  input  logic             opcode_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [POS_W-1:0] pos_z_i,
  input  logic [7:0]       tile_type_i,
  output logic             cmd_push_o,
  output vgc_cmd_t         cmd_o,
  input  logic             cmd_full_i
);

  logic x_ok, y_ok, z_ok;

  // Check each coordinate: non-negative and below its grid size
  assign x_ok = !pos_x_i[POS_W-1] && ({1'b0, pos_x_i[IDX_W-1:0]} < POS_W'(GRID_WIDTH));
  assign y_ok = !pos_y_i[POS_W-1] && ({1'b0, pos_y_i[IDX_W-1:0]} < POS_W'(GRID_HEIGHT));
  assign z_ok = !pos_z_i[POS_W-1] && ({1'b0, pos_z_i[IDX_W-1:0]} < POS_W'(GRID_LENGTH));

  // Classify the item and hand it to the command queue
  always_comb begin
    cmd_o.wr       = (opcode_i == OP_WRITE);
    cmd_o.in_range = x_ok && y_ok && z_ok;
    cmd_o.tile_nz  = (tile_type_i != 8'd0);
    cmd_o.pos_x    = pos_x_i[IDX_W-1:0];
    cmd_o.pos_y    = pos_y_i[IDX_W-1:0];
    cmd_o.pos_z    = pos_z_i[IDX_W-1:0];
  end

  assign cmd_push_o = push_i;
  assign full_o     = cmd_full_i;

endmodule

// ===== hw/rtl/vgc_back.sv =====
`timescale 1ns / 1ps

module vgc_back
  import vgc_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_LENGTH = 256,
  parameter int unsigned GRID_HEIGHT = 64
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  vgc_cmd_t cmd_i,
  input  logic     cmd_empty_i,
  output logic     cmd_pop_o,
  output vgc_res_t res_o,
  input  logic     res_full_i,
  output logic     res_push_o
);

  localparam int unsigned COLS      = GRID_WIDTH * GRID_LENGTH;
  localparam int unsigned AW        = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int unsigned TW        = $clog2(GRID_HEIGHT);
  localparam int unsigned H         = GRID_HEIGHT;
  localparam int unsigned MEM_W     = TW + H;
  localparam int unsigned RESET_TOP = GRID_HEIGHT * 2 / 3;
  localparam int unsigned PROD_W    = 2 * IDX_W + 1;
  localparam logic [H-1:0] RESET_BITS = {H{1'b1}} >> (H - 1 - RESET_TOP);

  // One word per column: {top height, solid bit per level}
  logic [MEM_W-1:0] mem [COLS];

  vgc_state_e       state_q, state_d;
  vgc_cmd_t         cmd_q;
  logic [AW-1:0]    addr_q;
  logic [AW-1:0]    clr_q;
  logic [MEM_W-1:0] rd_q;
  logic [H-1:0]     word_q;
  logic [TW-1:0]    old_top_q;
  logic [TW-1:0]    d_q;
  vgc_res_t         res_q;

  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [MEM_W-1:0] mem_wdata;
  logic [PROD_W-1:0] prod;
  logic [H-1:0]     rd_bits;
  logic [TW-1:0]    rd_top;
  logic [TW-1:0]    y_idx;
  logic [H-1:0]     word_mod;
  logic             clr_last;
  logic             scan_more;
  logic [TW-1:0]    span_lo, span_hi;

  function automatic logic [TOP_W-1:0] low6(input logic [TW-1:0] v);
    logic [EXT_W-1:0] e;
    e = EXT_W'(v);
    return e[TOP_W-1:0];
  endfunction

  // Column address and word fields
  assign prod      = PROD_W'(cmd_q.pos_z) * PROD_W'(GRID_WIDTH) + PROD_W'(cmd_q.pos_x);
  assign rd_bits   = rd_q[H-1:0];
  assign rd_top    = rd_q[H +: TW];
  assign y_idx     = cmd_q.pos_y[TW-1:0];
  assign clr_last  = (clr_q == AW'(COLS - 1));
  assign scan_more = (d_q != '0) && !word_q[d_q];
  assign span_lo   = (old_top_q < d_q) ? old_top_q : d_q;
  assign span_hi   = (old_top_q > d_q) ? old_top_q : d_q;

  always_comb begin
    word_mod        = rd_bits;
    word_mod[y_idx] = cmd_q.tile_nz;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: if (clr_last) state_d = ST_IDLE;
      ST_IDLE:  if (!cmd_empty_i) state_d = ST_ADDR;
      ST_ADDR:  state_d = cmd_q.in_range ? ST_READ : ST_DONE;
      ST_READ:  state_d = ST_EVAL;
      ST_EVAL:  state_d = cmd_q.wr ? ST_SCAN : ST_DONE;
      ST_SCAN:  if (!scan_more) state_d = ST_WRITE;
      ST_WRITE: state_d = ST_DONE;
      ST_DONE:  if (!res_full_i) state_d = ST_IDLE;
      default:  state_d = ST_CLEAR;
    endcase
  end

  // Outputs: queue handshakes and memory write port
  always_comb begin
    cmd_pop_o  = 1'b0;
    res_push_o = 1'b0;
    mem_we     = 1'b0;
    mem_waddr  = addr_q;
    mem_wdata  = {d_q, word_q};
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        mem_wdata = {TW'(RESET_TOP), RESET_BITS};
      end
      ST_IDLE:  cmd_pop_o = !cmd_empty_i;
      ST_WRITE: mem_we = 1'b1;
      ST_DONE:  res_push_o = 1'b1;
      default: ;
    endcase
  end

  assign res_o = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q   <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
    end
  end

  // Datapath: latch command, evaluate, rescan the column top-down
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      ST_IDLE: begin
        if (!cmd_empty_i) begin
          cmd_q <= cmd_i;
        end
      end
      ST_ADDR: begin
        addr_q <= prod[AW-1:0];
        res_q  <= '0;
      end
      ST_EVAL: begin
        res_q.is_solid <= rd_bits[y_idx];
        res_q.is_dark  <= (cmd_q.pos_y < EXT_W'(rd_top));
        if (!cmd_q.wr) begin
          res_q.column_top <= low6(rd_top);
        end
        word_q    <= word_mod;
        old_top_q <= rd_top;
        d_q       <= TW'(H - 1);
      end
      ST_SCAN: begin
        if (scan_more) begin
          d_q <= d_q - 1'b1;
        end
      end
      ST_WRITE: begin
        res_q.write_done     <= 1'b1;
        res_q.column_top     <= low6(d_q);
        res_q.column_changed <= (d_q != old_top_q);
        res_q.span_low       <= low6(span_lo);
        res_q.span_high      <= low6(span_hi);
      end
      default: ;
    endcase
  end

  // Column memory: one write port, registered read
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_q <= mem[addr_q];
  end

  a_no_pop_in_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CLEAR) |-> !cmd_pop_o)
    else $error("command taken during clearing pass");

  a_scan_descends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN && scan_more) |=> (d_q == $past(d_q) - 1'b1))
    else $error("column scan did not step down");

  a_top_is_solid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_WRITE) |-> (d_q == '0 || word_q[d_q]))
    else $error("stored column top is not a solid level");

endmodule

// ===== hw/rtl/voxel_grid_with_column_heights.sv =====
`timescale 1ns / 1ps

// Channel   Direction  Handshake            Payload
// input     in         push / full          opcode_i, pos_x_i, pos_y_i, pos_z_i, tile_type_i
// result    out        pop / empty          is_solid_o, is_dark_o, write_done_o, column_top_o,
//                                           column_changed_o, span_low_o, span_high_o
//
// A read steps through the back-end states ADDR, READ, EVAL and DONE; a write adds
// a top-down rescan of its column, one level per cycle, and a WRITE state.
// Each column lives in one memory word (top height plus one solid bit per level).
// After reset a clearing pass writes the start terrain into all GRID_WIDTH*GRID_LENGTH
// column words, one per cycle; no command is taken until it ends.
// Two-entry queues before and after the back end let the input and result sides stall
// independently.

module voxel_grid_with_column_heights
  import vgc_pkg::*;
#(
  parameter int unsigned GRID_WIDTH  = 256,
  parameter int unsigned GRID_LENGTH = 256,
  parameter int unsigned GRID_HEIGHT = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push,
  output logic             full,
  input  logic             opcode_i,
  input  logic [POS_W-1:0] pos_x_i,
  input  logic [POS_W-1:0] pos_y_i,
  input  logic [POS_W-1:0] pos_z_i,
  input  logic [7:0]       tile_type_i,
  output logic             empty,
  input  logic             pop,
  output logic             is_solid_o,
  output logic             is_dark_o,
  output logic             write_done_o,
  output logic [TOP_W-1:0] column_top_o,
  output logic             column_changed_o,
  output logic [TOP_W-1:0] span_low_o,
  output logic [TOP_W-1:0] span_high_o
);

  vgc_cmd_t front_cmd, back_cmd;
  vgc_res_t back_res, out_res;
  logic     cmd_push, cmd_full, cmd_pop, cmd_empty;
  logic     res_push, res_full;

  // Classify incoming items
  vgc_front #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_LENGTH(GRID_LENGTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_front (
    .push_i     (push),
    .full_o     (full),
    .opcode_i   (opcode_i),
    .pos_x_i    (pos_x_i),
    .pos_y_i    (pos_y_i),
    .pos_z_i    (pos_z_i),
    .tile_type_i(tile_type_i),
    .cmd_push_o (cmd_push),
    .cmd_o      (front_cmd),
    .cmd_full_i (cmd_full)
  );

  // Decouple front from back
  vgc_fifo #(
    .WIDTH($bits(vgc_cmd_t)),
    .DEPTH(2)
  ) u_cmd_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (cmd_push),
    .data_i (front_cmd),
    .full_o (cmd_full),
    .pop_i  (cmd_pop),
    .data_o (back_cmd),
    .empty_o(cmd_empty)
  );

  // Execute reads and writes against the column memory
  vgc_back #(
    .GRID_WIDTH (GRID_WIDTH),
    .GRID_LENGTH(GRID_LENGTH),
    .GRID_HEIGHT(GRID_HEIGHT)
  ) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (back_cmd),
    .cmd_empty_i(cmd_empty),
    .cmd_pop_o  (cmd_pop),
    .res_o      (back_res),
    .res_full_i (res_full),
    .res_push_o (res_push)
  );

  // Hold results until the consumer takes them
  vgc_fifo #(
    .WIDTH($bits(vgc_res_t)),
    .DEPTH(2)
  ) u_res_q (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (res_push),
    .data_i (back_res),
    .full_o (res_full),
    .pop_i  (pop),
    .data_o (out_res),
    .empty_o(empty)
  );

  assign is_solid_o       = out_res.is_solid;
  assign is_dark_o        = out_res.is_dark;
  assign write_done_o     = out_res.write_done;
  assign column_top_o     = out_res.column_top;
  assign column_changed_o = out_res.column_changed;
  assign span_low_o       = out_res.span_low;
  assign span_high_o      = out_res.span_high;

endmodule
